@@ sv/integer_to_padded_ascii_assert.svh @@
`ifndef INTEGER_TO_PADDED_ASCII_ASSERT_SVH
`define INTEGER_TO_PADDED_ASCII_ASSERT_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define ITPA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define ITPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/itpa_pkg.sv @@
package itpa_pkg;

  localparam int DEF_MAX_WIDTH     = 64;
  localparam int DEF_MAX_PRECISION = 63;

  localparam int VALUE_W = 64;
  localparam int WIDTH_W = 7;
  localparam int PREC_W  = 6;
  localparam int CNT_W   = 7;
  localparam int CHAR_W  = 8;

  localparam int NDIG      = 22;
  localparam int DIG_IDX_W = $clog2(NDIG);
  localparam int LEN_W     = $clog2(NDIG + 1);
  localparam int STEP_W    = $clog2(VALUE_W);

  localparam int IN_DATA_W = 80;

  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_HEXL = 3'd2,
    OP_HEXU = 3'd3,
    OP_OCT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_OCT
  } radix_t;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;

  typedef struct packed {
    logic [CNT_W-1:0]     t_lead;
    logic [CNT_W-1:0]     t_sign;
    logic [CNT_W-1:0]     t_zero;
    logic [CNT_W-1:0]     t_digit;
    logic [CNT_W-1:0]     total;
    logic [DIG_IDX_W-1:0] dptr;
    logic                 upper;
  } plan_t;

endpackage

@@ sv/itpa_digits.sv @@
module itpa_digits (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic                             step,
  input  logic                             bit_in,
  input  itpa_pkg::radix_t                 radix,
  input  logic [itpa_pkg::DIG_IDX_W-1:0]   rd_idx,
  output logic [3:0]                       rd_digit,
  output logic [itpa_pkg::LEN_W-1:0]       len
);
  import itpa_pkg::*;
  `include "integer_to_padded_ascii_assert.svh"

  logic [3:0] digit_r   [NDIG];
  logic [3:0] digit_nxt [NDIG];
  logic [4:0] rdx;
  logic [3:0] half;
  logic       over_dec;

  always_comb begin
    unique case (radix)
      RADIX_HEX: begin
        rdx  = 5'd16;
        half = 4'd8;
      end
      RADIX_OCT: begin
        rdx  = 5'd8;
        half = 4'd4;
      end
      default: begin
        rdx  = 5'd10;
        half = 4'd5;
      end
    endcase
  end

  // Each digit doubles and takes the carry of the digit below; the carry out
  // depends only on the old digit, so all digits update in parallel.
  always_comb begin
    logic [NDIG:0] carry;
    logic [4:0]    t;
    carry[0] = bit_in;
    for (int i = 0; i < NDIG; i++) begin
      carry[i+1]   = digit_r[i] >= half;
      t            = {digit_r[i], carry[i]};
      digit_nxt[i] = carry[i+1] ? 4'(t - rdx) : t[3:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NDIG; i++) begin
      if (!rst_n || clear) begin
        digit_r[i] <= '0;
      end else if (step) begin
        digit_r[i] <= digit_nxt[i];
      end
    end
  end

  assign rd_digit = (32'(rd_idx) < NDIG) ? digit_r[rd_idx] : 4'd0;

  always_comb begin
    len      = '0;
    over_dec = 1'b0;
    for (int i = 0; i < NDIG; i++) begin
      if (digit_r[i] != 4'd0) begin
        len = LEN_W'(i + 1);
      end
      if (digit_r[i] > 4'd9) begin
        over_dec = 1'b1;
      end
    end
  end

  `ITPA_ASSERT_SAME(a_dec_digit_range, radix == RADIX_DEC, !over_dec,
    "Decimal digit store holds a digit above nine.")
  `ITPA_ASSERT_NEXT(a_clear_empties, clear, len == '0,
    "Digit store is not empty after clear.")

endmodule

@@ sv/itpa_emit.sv @@
module itpa_emit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  itpa_pkg::plan_t                  plan,
  input  logic [3:0]                       digit,
  output logic [itpa_pkg::DIG_IDX_W-1:0]   dig_idx,
  output logic                             busy,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [itpa_pkg::CHAR_W-1:0]      out_tdata,
  output logic                             out_tlast
);
  import itpa_pkg::*;
  `include "integer_to_padded_ascii_assert.svh"

  plan_t                plan_r;
  logic                 active_r;
  logic [CNT_W-1:0]     pos_r;
  logic [DIG_IDX_W-1:0] dptr_r;
  logic                 out_tvalid_r;
  logic [CHAR_W-1:0]    out_tdata_r;
  logic                 out_tlast_r;
  logic                 advance;
  logic                 in_digits;
  logic                 is_last;
  logic [CHAR_W-1:0]    ch;
  logic [CHAR_W-1:0]    dig_ch;

  assign advance   = active_r && (!out_tvalid_r || out_tready);
  assign in_digits = (pos_r >= plan_r.t_zero) && (pos_r < plan_r.t_digit);
  assign is_last   = pos_r == CNT_W'(plan_r.total - 1'b1);

  always_comb begin
    if (digit < 4'd10) begin
      dig_ch = CH_ZERO + CHAR_W'(digit);
    end else begin
      dig_ch = (plan_r.upper ? CH_UP_A : CH_LO_A) + CHAR_W'(digit - 4'd10);
    end
  end

  always_comb begin
    priority if (pos_r < plan_r.t_lead) begin
      ch = CH_SPACE;
    end else if (pos_r < plan_r.t_sign) begin
      ch = CH_MINUS;
    end else if (pos_r < plan_r.t_zero) begin
      ch = CH_ZERO;
    end else if (pos_r < plan_r.t_digit) begin
      ch = dig_ch;
    end else begin
      ch = CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (start) begin
        plan_r   <= plan;
        pos_r    <= '0;
        dptr_r   <= plan.dptr;
        active_r <= 1'b1;
      end else if (advance) begin
        pos_r <= pos_r + 1'b1;
        if (in_digits) begin
          dptr_r <= dptr_r - 1'b1;
        end
        if (is_last) begin
          active_r <= 1'b0;
        end
      end
      if (advance) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= ch;
        out_tlast_r  <= is_last;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign dig_idx    = dptr_r;
  assign busy       = active_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `ITPA_ASSERT_SAME(a_pos_in_range, active_r, pos_r < plan_r.total,
    "Character position ran past the end of the text.")
  `ITPA_ASSERT_NEXT(a_last_stops, advance && is_last, !active_r || start,
    "Sequencer kept running after the final character.")

endmodule

@@ sv/integer_to_padded_ascii.sv @@
// Formats one 64-bit integer per input transaction as printf-style ASCII text
// and sends it one character per output transaction, with tlast on the final
// character. A transaction is accepted in the idle cycle, then passes through
// the shared digit unit (one value bit shifted into all digits per cycle, for
// every conversion kind), the length and padding setup states S_LEN, S_PAD and
// S_SETUP, and output at one character per cycle while the output side is
// ready (at most 64 characters), and the controller then returns to idle.
// The block takes no new input until the last character has been loaded into
// the output register and the controller is back in idle; when the text is
// empty it goes from setup straight back to idle. An item whose text is
// empty (zero value, explicit precision zero, width zero) gives no output.
module integer_to_padded_ascii #(
  parameter int MAX_WIDTH     = itpa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PRECISION = itpa_pkg::DEF_MAX_PRECISION
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // value[63:0], zero_pad[64], left_adjust[65], width[72:66],
  // has_precision[73], precision[79:74]
  input  logic [itpa_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // character[7:0]
  output logic [itpa_pkg::CHAR_W-1:0]     out_tdata,
  output logic                            out_tlast
);
  import itpa_pkg::*;
  `include "integer_to_padded_ascii_assert.svh"

  localparam logic [WIDTH_W-1:0] MAXW = WIDTH_W'(MAX_WIDTH);
  localparam logic [PREC_W-1:0]  MAXP = PREC_W'(MAX_PRECISION);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_LEN,
    S_PAD,
    S_SETUP,
    S_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [VALUE_W-1:0]   mag_r;
  logic [STEP_W-1:0]    step_cnt_r;
  logic                 minus_r;
  radix_t               radix_r;
  logic                 upper_r;
  logic                 zpad_r;
  logic                 left_r;
  logic [WIDTH_W-1:0]   width_r;
  logic [PREC_W-1:0]    prec_r;
  logic [LEN_W-1:0]     len_r;
  logic [PREC_W-1:0]    precf_r;
  logic [CNT_W-1:0]     pad_r;

  logic                 accept;
  logic [VALUE_W-1:0]   in_value;
  logic                 in_zero_pad;
  logic                 in_left_adjust;
  logic [WIDTH_W-1:0]   in_width;
  logic                 in_has_precision;
  logic [PREC_W-1:0]    in_precision;
  logic                 neg;
  radix_t               in_radix;
  logic                 in_upper;

  logic [LEN_W-1:0]     len;
  logic [3:0]           rd_digit;
  logic [DIG_IDX_W-1:0] dig_idx;
  logic                 emit_busy;
  logic                 start;
  plan_t                plan;
  logic [CNT_W-1:0]     body;
  logic [CNT_W-1:0]     lead_pad;
  logic [CNT_W-1:0]     zero_pad_cnt;

  assign in_value         = in_tdata[63:0];
  assign in_zero_pad      = in_tdata[64];
  assign in_left_adjust   = in_tdata[65];
  assign in_width         = in_tdata[72:66];
  assign in_has_precision = in_tdata[73];
  assign in_precision     = in_tdata[79:74];

  assign in_tready = state_r == S_IDLE;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    neg      = 1'b0;
    in_upper = 1'b0;
    unique case (in_tuser)
      OP_SDEC: begin
        in_radix = RADIX_DEC;
        neg      = in_value[VALUE_W-1];
      end
      OP_HEXL: in_radix = RADIX_HEX;
      OP_HEXU: begin
        in_radix = RADIX_HEX;
        in_upper = 1'b1;
      end
      OP_OCT:  in_radix = RADIX_OCT;
      default: in_radix = RADIX_DEC;
    endcase
  end

  assign body         = CNT_W'(minus_r) + CNT_W'(precf_r);
  assign lead_pad     = (!left_r && !zpad_r) ? pad_r : '0;
  assign zero_pad_cnt = (!left_r && zpad_r) ? pad_r : '0;

  always_comb begin
    plan.t_lead  = lead_pad;
    plan.t_sign  = lead_pad + CNT_W'(minus_r);
    plan.t_digit = plan.t_sign + zero_pad_cnt + CNT_W'(precf_r);
    plan.t_zero  = plan.t_digit - CNT_W'(len_r);
    plan.total   = pad_r + body;
    plan.dptr    = DIG_IDX_W'(len_r - 1'b1);
    plan.upper   = upper_r;
  end

  assign start = (state_r == S_SETUP) && (plan.total != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CONV;
      S_CONV:  if (step_cnt_r == '1) state_nxt = S_LEN;
      S_LEN:   state_nxt = S_PAD;
      S_PAD:   state_nxt = S_SETUP;
      S_SETUP: state_nxt = start ? S_EMIT : S_IDLE;
      S_EMIT:  if (!emit_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      radix_r <= RADIX_DEC;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        mag_r      <= neg ? VALUE_W'(-in_value) : in_value;
        minus_r    <= neg;
        radix_r    <= in_radix;
        upper_r    <= in_upper;
        zpad_r     <= in_zero_pad && !in_has_precision;
        left_r     <= in_left_adjust;
        width_r    <= (in_width > MAXW) ? MAXW : in_width;
        prec_r     <= !in_has_precision ? PREC_W'(1)
                    : ((in_precision > MAXP) ? MAXP : in_precision);
        step_cnt_r <= '0;
      end
      if (state_r == S_CONV) begin
        mag_r      <= {mag_r[VALUE_W-2:0], 1'b0};
        step_cnt_r <= step_cnt_r + 1'b1;
      end
      if (state_r == S_LEN) begin
        len_r   <= len;
        precf_r <= (PREC_W'(len) > prec_r) ? PREC_W'(len) : prec_r;
      end
      if (state_r == S_PAD) begin
        pad_r <= (CNT_W'(width_r) > body) ? CNT_W'(width_r) - body : '0;
      end
    end
  end

  itpa_digits u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (accept),
    .step     (state_r == S_CONV),
    .bit_in   (mag_r[VALUE_W-1]),
    .radix    (radix_r),
    .rd_idx   (dig_idx),
    .rd_digit (rd_digit),
    .len      (len)
  );

  itpa_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .plan       (plan),
    .digit      (rd_digit),
    .dig_idx    (dig_idx),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `ITPA_ASSERT_SAME(a_no_start_in_conv, state_r == S_CONV, !start && !emit_busy,
    "Character sequencer is active during digit conversion.")
  `ITPA_ASSERT_NEXT(a_setup_goes_emit, start, state_r == S_EMIT && emit_busy,
    "Setup did not hand the plan to the character sequencer.")

endmodule

@@ bench/integer_to_padded_ascii_test.sv @@
`timescale 1ns / 1ps

module integer_to_padded_ascii_test;
  import itpa_pkg::*;

  localparam int SAT_WIDTH    = DEF_MAX_WIDTH;
  localparam int SAT_PREC     = DEF_MAX_PRECISION;
  localparam int CHAR_CAP     = 64;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    logic [63:0] value;
    logic [2:0]  op;
    logic        zero_pad;
    logic        left_adjust;
    logic [6:0]  width;
    logic        has_prec;
    logic [5:0]  prec;
  } fmt_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [CHAR_W-1:0] out_tdata;
  logic out_tlast;

  char_beat_t pending_chars[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int empty_items = 0;
  int chars_checked = 0;
  int cycle_count = 0;

  integer_to_padded_ascii u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic fmt_req_t make_req(logic [63:0] value, logic [2:0] op, logic zero_pad,
                                        logic left_adjust, logic [6:0] width,
                                        logic has_prec, logic [5:0] prec);
    fmt_req_t r;
    r.value = value;
    r.op = op;
    r.zero_pad = zero_pad;
    r.left_adjust = left_adjust;
    r.width = width;
    r.has_prec = has_prec;
    r.prec = prec;
    return r;
  endfunction

  // Appends the characters that one transaction must produce to pending_chars.
  function automatic void format_integer(fmt_req_t r);
    logic [63:0] mag;
    logic [CHAR_W-1:0] digs [24];
    logic [CHAR_W-1:0] text [$];
    logic [3:0] nib;
    logic minus;
    logic zpad;
    int len;
    int prec;
    int fw;
    int pad;
    int n;
    char_beat_t beat;
    mag = r.value;
    minus = 1'b0;
    zpad = r.zero_pad;
    len = 0;
    fw = (int'(r.width) > SAT_WIDTH) ? SAT_WIDTH : int'(r.width);
    if (r.has_prec) begin
      prec = (int'(r.prec) > SAT_PREC) ? SAT_PREC : int'(r.prec);
      zpad = 1'b0;
    end else begin
      prec = 1;
    end
    if (r.op == OP_HEXL || r.op == OP_HEXU) begin
      while (mag != 0) begin
        nib = mag[3:0];
        if (nib >= 4'd10)
          digs[len] = ((r.op == OP_HEXL) ? CH_LO_A : CH_UP_A) + CHAR_W'(nib - 4'd10);
        else
          digs[len] = CH_ZERO + CHAR_W'(nib);
        len++;
        mag = mag >> 4;
      end
    end else if (r.op == OP_OCT) begin
      while (mag != 0) begin
        digs[len] = CH_ZERO + CHAR_W'(mag[2:0]);
        len++;
        mag = mag >> 3;
      end
    end else begin
      if (r.op == OP_SDEC && mag[63]) begin
        minus = 1'b1;
        mag = -mag;
      end
      while (mag != 0) begin
        digs[len] = CH_ZERO + CHAR_W'(mag % 10);
        len++;
        mag = mag / 10;
      end
    end
    if (prec < len)
      prec = len;
    pad = (fw > int'(minus) + prec) ? fw - (int'(minus) + prec) : 0;
    if (!r.left_adjust && !zpad)
      repeat (pad) text.push_back(CH_SPACE);
    if (minus)
      text.push_back(CH_MINUS);
    if (!r.left_adjust && zpad)
      repeat (pad) text.push_back(CH_ZERO);
    repeat (prec - len) text.push_back(CH_ZERO);
    for (int i = len - 1; i >= 0; i--)
      text.push_back(digs[i]);
    if (r.left_adjust)
      repeat (pad) text.push_back(CH_SPACE);
    n = (text.size() > CHAR_CAP) ? CHAR_CAP : text.size();
    if (n == 0)
      empty_items++;
    for (int i = 0; i < n; i++) begin
      beat.ch = text[i];
      beat.last = (i == n - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  task automatic send_item(fmt_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r.prec, r.has_prec, r.width, r.left_adjust, r.zero_pad, r.value};
    in_tuser <= r.op;
    do @(posedge clk); while (!in_tready);
    format_integer(r);
    items_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_chars.size() == 0) begin
        $error("output transaction 0x%02h with no expected character", out_tdata);
        fail_count++;
      end else begin
        if (out_tdata !== pending_chars[0].ch) begin
          $error("character: expected 0x%02h, actual 0x%02h", pending_chars[0].ch, out_tdata);
          fail_count++;
        end
        if (out_tlast !== pending_chars[0].last) begin
          $error("last: expected %0b, actual %0b", pending_chars[0].last, out_tlast);
          fail_count++;
        end
        void'(pending_chars.pop_front());
        chars_checked++;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(5))
      0: v = 64'($urandom_range(20));
      1: v = {$urandom, $urandom};
      2: v = ~64'($urandom_range(1000));
      3: begin
        v = 64'd1 << $urandom_range(63);
        if ($urandom_range(1))
          v = v - 64'd1;
      end
      4: v = {32'd0, $urandom};
      default: v = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    return v;
  endfunction

  function automatic fmt_req_t rand_req();
    fmt_req_t r;
    r.value = rand_value();
    if ($urandom_range(19) == 0)
      r.op = 3'($urandom_range(7, OP_OCT + 1));
    else
      r.op = 3'($urandom_range(OP_OCT));
    r.zero_pad = 1'($urandom_range(1));
    r.left_adjust = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1: r.width = '0;
      2: r.width = 7'($urandom_range(127));
      default: r.width = 7'($urandom_range(24));
    endcase
    r.has_prec = 1'($urandom_range(1));
    r.prec = ($urandom_range(5) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(24));
    return r;
  endfunction

  task automatic test_directed_cases();
    send_item(make_req(64'd0, OP_SDEC, 1'b0, 1'b0, 7'd0, 1'b0, 6'd0));
    send_item(make_req(64'd0, OP_UDEC, 1'b0, 1'b0, 7'd0, 1'b1, 6'd0));
    send_item(make_req(64'd0, OP_HEXL, 1'b1, 1'b0, 7'd5, 1'b1, 6'd0));
    send_item(make_req(64'h8000_0000_0000_0000, OP_SDEC, 1'b0, 1'b0, 7'd0, 1'b0, 6'd0));
    send_item(make_req('1, OP_SDEC, 1'b1, 1'b0, 7'd10, 1'b0, 6'd0));
    send_item(make_req('1, OP_UDEC, 1'b0, 1'b0, 7'd0, 1'b0, 6'd0));
    send_item(make_req('1, OP_HEXL, 1'b0, 1'b1, 7'd20, 1'b0, 6'd0));
    send_item(make_req(64'hdead_beef_cafe_1234, OP_HEXU, 1'b1, 1'b0, 7'd24, 1'b0, 6'd0));
    send_item(make_req('1, OP_OCT, 1'b0, 1'b0, 7'd0, 1'b0, 6'd0));
    send_item(make_req(-64'sd42, OP_SDEC, 1'b1, 1'b0, 7'd12, 1'b1, 6'd5));
    send_item(make_req(64'd123, OP_UDEC, 1'b1, 1'b1, 7'd8, 1'b0, 6'd0));
    send_item(make_req(64'd7, OP_OCT, 1'b0, 1'b0, 7'd127, 1'b0, 6'd0));
    send_item(make_req('1, OP_SDEC, 1'b0, 1'b0, 7'd0, 1'b1, 6'd63));
    send_item(make_req(64'd0, OP_UDEC, 1'b0, 1'b1, 7'd64, 1'b1, 6'd63));
    send_item(make_req(-64'sd5, OP_SDEC, 1'b1, 1'b0, 7'd64, 1'b0, 6'd0));
    for (int c = OP_OCT + 1; c < 8; c++)
      send_item(make_req(64'hf000_0000_0000_0009, 3'(c), 1'b0, 1'b0, 7'd3, 1'b0, 6'd0));
    send_item(make_req(64'h0123_4567_89ab_cdef, OP_HEXL, 1'b0, 1'b0, 7'd0, 1'b1, 6'd20));
    send_item(make_req(64'd1, OP_OCT, 1'b1, 1'b0, 7'd3, 1'b0, 6'd0));
    send_item(make_req(64'h7fff_ffff_ffff_ffff, OP_SDEC, 1'b0, 1'b1, 7'd25, 1'b1, 6'd21));
  endtask

  task automatic test_random_formats(int count);
    repeat (count) send_item(rand_req());
  endtask

  task automatic test_drain_pause();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 58;
    test_directed_cases();
    test_random_formats(145);
    test_drain_pause();

    send_idle_pct = 58;
    recv_idle_pct = 14;
    test_random_formats(145);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_formats(150);

    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Formatted %0d integers over all conversion kinds, flags, widths and precisions.",
             items_sent);
    $display("Checked %0d characters; %0d integers gave empty text.", chars_checked,
             empty_items);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
